>>> hdl/lfps_pkg.sv
package lfps_pkg;

    localparam int PADDR_BITS  = 4;
    localparam int PDATA_BITS  = 32;
    localparam int QUOT_BITS   = 6;
    localparam int GAIN_BITS   = 16;
    localparam int ERROR_BITS  = 7;
    localparam int DRIVE_BITS  = 8;
    localparam int DUTY_BITS   = 10;
    localparam int SPEED_BITS  = 8;
    localparam int PROD_BITS   = GAIN_BITS + DRIVE_BITS;
    localparam int ACC_BITS    = PROD_BITS + 2;

    // register indexes, paddr[3:2]
    localparam logic [1:0] REG_KP   = 2'd0;
    localparam logic [1:0] REG_KI   = 2'd1;
    localparam logic [1:0] REG_KD   = 2'd2;
    localparam logic [1:0] REG_BASE = 2'd3;

    localparam logic signed [GAIN_BITS-1:0] KP_RESET   = 16'sd205;
    localparam logic signed [GAIN_BITS-1:0] KI_RESET   = 16'sd154;
    localparam logic signed [GAIN_BITS-1:0] KD_RESET   = 16'sd0;
    localparam logic [SPEED_BITS-1:0]       BASE_RESET = 8'd100;

    typedef struct packed {
        logic signed [GAIN_BITS-1:0] kp_gain;
        logic signed [GAIN_BITS-1:0] ki_gain;
        logic signed [GAIN_BITS-1:0] kd_gain;
        logic [SPEED_BITS-1:0]       base_speed;
    } lfps_cfg_t;

endpackage

>>> hdl/lfps_in_if.sv
interface lfps_in_if #(
    parameter int SENSOR_BITS = 8
);
    logic                   valid;
    logic                   ready;
    logic [SENSOR_BITS-1:0] sensor_far_left;
    logic [SENSOR_BITS-1:0] sensor_left;
    logic [SENSOR_BITS-1:0] sensor_center;
    logic [SENSOR_BITS-1:0] sensor_right;
    logic [SENSOR_BITS-1:0] sensor_far_right;

    modport source (
        output valid, sensor_far_left, sensor_left, sensor_center,
               sensor_right, sensor_far_right,
        input  ready
    );
    modport sink (
        input  valid, sensor_far_left, sensor_left, sensor_center,
               sensor_right, sensor_far_right,
        output ready
    );
endinterface

>>> hdl/lfps_out_if.sv
interface lfps_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lfps_pkg::ERROR_BITS-1:0] position_error;
    logic signed [lfps_pkg::DRIVE_BITS-1:0] drive_value;
    logic signed [lfps_pkg::DUTY_BITS-1:0]  duty_first;
    logic signed [lfps_pkg::DUTY_BITS-1:0]  duty_second;
    logic                                  no_signal;

    modport source (
        output valid, position_error, drive_value, duty_first, duty_second, no_signal,
        input  ready
    );
    modport sink (
        input  valid, position_error, drive_value, duty_first, duty_second, no_signal,
        output ready
    );
endinterface

>>> hdl/lfps_regs.sv
module lfps_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lfps_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [lfps_pkg::PDATA_BITS-1:0]   pwdata,
    output logic [lfps_pkg::PDATA_BITS-1:0]   prdata,
    output logic                              pready,
    output lfps_pkg::lfps_cfg_t               cfg
);

    lfps_pkg::lfps_cfg_t cfg_reg;
    lfps_pkg::lfps_cfg_t cfg_next;
    logic                wr_en;
    logic [1:0]          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                lfps_pkg::REG_KP:   cfg_next.kp_gain    = pwdata[15:0];
                lfps_pkg::REG_KI:   cfg_next.ki_gain    = pwdata[15:0];
                lfps_pkg::REG_KD:   cfg_next.kd_gain    = pwdata[15:0];
                lfps_pkg::REG_BASE: cfg_next.base_speed = pwdata[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            lfps_pkg::REG_KP:   prdata = 32'($signed(cfg_reg.kp_gain));
            lfps_pkg::REG_KI:   prdata = 32'($signed(cfg_reg.ki_gain));
            lfps_pkg::REG_KD:   prdata = 32'($signed(cfg_reg.kd_gain));
            lfps_pkg::REG_BASE: prdata = {24'd0, cfg_reg.base_speed};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_gain    <= lfps_pkg::KP_RESET;
            cfg_reg.ki_gain    <= lfps_pkg::KI_RESET;
            cfg_reg.kd_gain    <= lfps_pkg::KD_RESET;
            cfg_reg.base_speed <= lfps_pkg::BASE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hdl/line_follow_pid_steering.sv
// Sequence from input transaction to result valid: 6 restoring-division steps,
// 1 state update, 3 shared multiply steps, 1 finish (held while output stalled).
// The single divide subtractor and the single 16x8 multiplier are reused in turn;
// input ready only when idle, so a new item waits until the last one is finished.
// Reset (rst_n, async, active low): sequencer idle, no result pending,
// integral and previous error cleared, gains and base speed to defaults.
module line_follow_pid_steering #(
    parameter int SENSOR_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    lfps_in_if.sink                           sensor_in,
    lfps_out_if.source                        result_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lfps_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [lfps_pkg::PDATA_BITS-1:0]   pwdata,
    output logic [lfps_pkg::PDATA_BITS-1:0]   prdata,
    output logic                              pready
);

    localparam int SUM_W = SENSOR_BITS + 3;
    localparam int ABS_W = SENSOR_BITS + 2;
    localparam int MAG_W = SENSOR_BITS + 7;
    localparam int DIV_W = SENSOR_BITS + 8;
    localparam int EW    = lfps_pkg::ERROR_BITS;
    localparam int DW    = lfps_pkg::DRIVE_BITS;
    localparam int AW    = lfps_pkg::ACC_BITS;
    localparam int QW    = AW - 8;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_CALC = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    lfps_pkg::lfps_cfg_t cfg;

    lfps_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [2:0]                     state_reg, state_next;
    logic [2:0]                     cnt_reg, cnt_next;
    logic [SUM_W-1:0]               sum_reg, sum_next;
    logic [MAG_W-1:0]               rem_reg, rem_next;
    logic [lfps_pkg::QUOT_BITS-1:0] quot_reg, quot_next;
    logic                           neg_reg, neg_next;
    logic                           none_reg, none_next;
    logic signed [EW-1:0]           err_reg, err_next;
    logic signed [EW-1:0]           prev_reg, prev_next;
    logic signed [DW-1:0]           integ_reg, integ_next;
    logic signed [DW-1:0]           diff_reg, diff_next;
    logic signed [AW-1:0]           acc_reg, acc_next;

    logic                           ovalid_reg, ovalid_next;
    logic signed [EW-1:0]           oerr_reg, oerr_next;
    logic signed [DW-1:0]           odrv_reg, odrv_next;
    logic signed [lfps_pkg::DUTY_BITS-1:0] oduty1_reg, oduty1_next;
    logic signed [lfps_pkg::DUTY_BITS-1:0] oduty2_reg, oduty2_next;
    logic                           onone_reg, onone_next;

    // input side: weighted numerator as magnitude and sign
    logic [ABS_W-1:0]               pos_w, neg_w, abs_w;
    logic [SUM_W-1:0]               sum_w;
    logic [MAG_W-1:0]               mag_w;

    // shared divide step
    logic [DIV_W-1:0]               dvs_sh, rem_ext;
    logic                           ge_w;

    // shared multiplier
    logic signed [lfps_pkg::GAIN_BITS-1:0] gain_op;
    logic signed [DW-1:0]           data_op;
    logic signed [lfps_pkg::PROD_BITS-1:0] prod_w;

    logic signed [EW-1:0]           e_w;
    logic signed [QW-1:0]           q_w;
    logic signed [DW-1:0]           drv_w;
    logic                           out_free;

    assign pos_w = ABS_W'(sensor_in.sensor_right) + {1'b0, sensor_in.sensor_far_right, 1'b0};
    assign neg_w = ABS_W'(sensor_in.sensor_left) + {1'b0, sensor_in.sensor_far_left, 1'b0};
    assign abs_w = (neg_w > pos_w) ? (neg_w - pos_w) : (pos_w - neg_w);
    assign sum_w = SUM_W'(sensor_in.sensor_far_left) + SUM_W'(sensor_in.sensor_left)
                 + SUM_W'(sensor_in.sensor_center) + SUM_W'(sensor_in.sensor_right)
                 + SUM_W'(sensor_in.sensor_far_right);
    // x17 = x16 + x1
    assign mag_w = MAG_W'({abs_w, 4'b0000}) + MAG_W'(abs_w);

    assign dvs_sh  = DIV_W'(sum_reg) << cnt_reg;
    assign rem_ext = DIV_W'(rem_reg);
    assign ge_w    = rem_ext >= dvs_sh;

    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:    begin gain_op = cfg.kp_gain; data_op = DW'(err_reg); end
            2'd1:    begin gain_op = cfg.ki_gain; data_op = integ_reg;    end
            default: begin gain_op = cfg.kd_gain; data_op = diff_reg;     end
        endcase
    end

    assign prod_w = gain_op * data_op;

    assign e_w = none_reg ? '0
               : (neg_reg ? -$signed({1'b0, quot_reg}) : $signed({1'b0, quot_reg}));

    // divide by 256 truncating toward zero, then saturate
    assign q_w = $signed(acc_reg[AW-1:8])
               + $signed({{(QW-1){1'b0}}, (acc_reg[AW-1] && (acc_reg[7:0] != 8'd0))});

    always_comb
    begin
        priority if (q_w > $signed(QW'(127)))
            drv_w = 8'sd127;
        else if (q_w < $signed(-QW'(128)))
            drv_w = -8'sd128;
        else
            drv_w = q_w[DW-1:0];
    end

    assign out_free         = !ovalid_reg || result_out.ready;
    assign sensor_in.ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        sum_next    = sum_reg;
        rem_next    = rem_reg;
        quot_next   = quot_reg;
        neg_next    = neg_reg;
        none_next   = none_reg;
        err_next    = err_reg;
        prev_next   = prev_reg;
        integ_next  = integ_reg;
        diff_next   = diff_reg;
        acc_next    = acc_reg;
        ovalid_next = ovalid_reg && !result_out.ready;
        oerr_next   = oerr_reg;
        odrv_next   = odrv_reg;
        oduty1_next = oduty1_reg;
        oduty2_next = oduty2_reg;
        onone_next  = onone_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sensor_in.valid)
                begin
                    sum_next   = sum_w;
                    rem_next   = mag_w;
                    neg_next   = neg_w > pos_w;
                    none_next  = (sum_w == '0);
                    quot_next  = '0;
                    cnt_next   = 3'(lfps_pkg::QUOT_BITS - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                quot_next = {quot_reg[lfps_pkg::QUOT_BITS-2:0], ge_w};
                if (ge_w)
                    rem_next = MAG_W'(rem_ext - dvs_sh);
                if (cnt_reg == 3'd0)
                    state_next = ST_CALC;
                else
                    cnt_next = cnt_reg - 3'd1;
            end
            ST_CALC:
            begin
                err_next   = e_w;
                prev_next  = e_w;
                integ_next = integ_reg + DW'(e_w);
                diff_next  = DW'(e_w) - DW'(prev_reg);
                acc_next   = '0;
                cnt_next   = 3'd0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                acc_next = acc_reg + AW'(prod_w);
                if (cnt_reg == 3'd2)
                    state_next = ST_FIN;
                else
                    cnt_next = cnt_reg + 3'd1;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    oerr_next   = err_reg;
                    odrv_next   = drv_w;
                    oduty1_next = $signed({2'b00, cfg.base_speed}) - 10'(drv_w);
                    oduty2_next = $signed({2'b00, cfg.base_speed}) + 10'(drv_w);
                    onone_next  = none_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            prev_reg   <= '0;
            integ_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            prev_reg   <= prev_next;
            integ_reg  <= integ_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg    <= sum_next;
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        neg_reg    <= neg_next;
        none_reg   <= none_next;
        err_reg    <= err_next;
        diff_reg   <= diff_next;
        acc_reg    <= acc_next;
        oerr_reg   <= oerr_next;
        odrv_reg   <= odrv_next;
        oduty1_reg <= oduty1_next;
        oduty2_reg <= oduty2_next;
        onone_reg  <= onone_next;
    end

    assign result_out.valid          = ovalid_reg;
    assign result_out.position_error = oerr_reg;
    assign result_out.drive_value    = odrv_reg;
    assign result_out.duty_first     = oduty1_reg;
    assign result_out.duty_second    = oduty2_reg;
    assign result_out.no_signal      = onone_reg;

    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        sensor_in.valid && sensor_in.ready |=> state_reg == ST_DIV)
        else $error("accepted transaction did not start division");

    a_none_zero_err: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && result_out.no_signal |-> result_out.position_error == '0)
        else $error("no_signal with non-zero position error");

    a_duty_pair: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |->
            (11'(result_out.duty_second) - 11'(result_out.duty_first))
            == 11'($signed({result_out.drive_value, 1'b0})))
        else $error("duties not symmetric about base speed");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN && ovalid_reg && !result_out.ready |=> state_reg == ST_FIN)
        else $error("result overwritten while output stalled");

endmodule

>>> bench/tb.sv
module tb;

    localparam int SENSOR_BITS     = 8;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 24;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int MAX_GAP         = 30;
    localparam int ERR_SCALE       = 17;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;
    typedef enum logic [1:0] { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_mode_t;

    typedef struct packed {
        logic [SENSOR_BITS-1:0] far_left;
        logic [SENSOR_BITS-1:0] left;
        logic [SENSOR_BITS-1:0] center;
        logic [SENSOR_BITS-1:0] right;
        logic [SENSOR_BITS-1:0] far_right;
    } sample_t;

    typedef struct packed {
        logic signed [lfps_pkg::ERROR_BITS-1:0] position_error;
        logic signed [lfps_pkg::DRIVE_BITS-1:0] drive_value;
        logic signed [lfps_pkg::DUTY_BITS-1:0]  duty_first;
        logic signed [lfps_pkg::DUTY_BITS-1:0]  duty_second;
        logic                                   no_signal;
    } steer_res_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic [15:0] reg_val;
        sample_t     smp;
        logic        typed;
        steer_res_t  res;
    } dir_row_t;

    localparam sample_t    NO_SAMPLE = '0;
    localparam steer_res_t NO_RESULT = '0;
    localparam int         DIR_ROWS  = 25;

    // typed results hold for the reset gains and are read straight off the equations
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{ROW_ITEM, lfps_pkg::REG_KP, 16'h0, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
          '{7'sd0, 8'sd0, 10'sd100, 10'sd100, 1'b1}},
        '{ROW_ITEM, lfps_pkg::REG_KP, 16'h0, '{8'd255, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
          '{-7'sd34, -8'sd47, 10'sd147, 10'sd53, 1'b0}},
        '{ROW_ITEM, lfps_pkg::REG_KP, 16'h0, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
          '{7'sd0, -8'sd20, 10'sd120, 10'sd80, 1'b1}},
        '{ROW_ITEM, lfps_pkg::REG_KP, 16'h0, '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b0,
          NO_RESULT},
        // hard right, repeated until the integral wraps
        '{ROW_ITEM, lfps_pkg::REG_KP, 16'h0, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255}, 1'b0, NO_RESULT},
        '{ROW_ITEM, lfps_pkg::REG_KP, 16'h0, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255}, 1'b0, NO_RESULT},
        '{ROW_ITEM, lfps_pkg::REG_KP, 16'h0, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255}, 1'b0, NO_RESULT},
        '{ROW_ITEM, lfps_pkg::REG_KP, 16'h0, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255}, 1'b0, NO_RESULT},
        '{ROW_ITEM, lfps_pkg::REG_KP, 16'h0, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255}, 1'b0, NO_RESULT},
        '{ROW_ITEM, lfps_pkg::REG_KP, 16'h0, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255}, 1'b0, NO_RESULT},
        '{ROW_ITEM, lfps_pkg::REG_KP, 16'h0, '{8'd0, 8'd255, 8'd0, 8'd0, 8'd0}, 1'b0, NO_RESULT},
        '{ROW_ITEM, lfps_pkg::REG_KP, 16'h0, '{8'd0, 8'd0, 8'd0, 8'd255, 8'd0}, 1'b0, NO_RESULT},
        '{ROW_ITEM, lfps_pkg::REG_KP, 16'h0, '{8'd1, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, NO_RESULT},
        '{ROW_ITEM, lfps_pkg::REG_KP, 16'h0, '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5}, 1'b0, NO_RESULT},
        '{ROW_ITEM, lfps_pkg::REG_KP, 16'h0, '{8'd5, 8'd4, 8'd3, 8'd2, 8'd1}, 1'b0, NO_RESULT},
        '{ROW_ITEM, lfps_pkg::REG_KP, 16'h0, '{8'd0, 8'd0, 8'd255, 8'd0, 8'd0}, 1'b0, NO_RESULT},
        '{ROW_CFG, lfps_pkg::REG_KD, 16'h7fff, NO_SAMPLE, 1'b0, NO_RESULT},
        '{ROW_CFG, lfps_pkg::REG_KP, 16'h7fff, NO_SAMPLE, 1'b0, NO_RESULT},
        '{ROW_CFG, lfps_pkg::REG_KI, 16'h8000, NO_SAMPLE, 1'b0, NO_RESULT},
        '{ROW_CFG, lfps_pkg::REG_BASE, 16'h00ff, NO_SAMPLE, 1'b0, NO_RESULT},
        '{ROW_ITEM, lfps_pkg::REG_KP, 16'h0, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255}, 1'b0, NO_RESULT},
        // lost line: derivative is minus the previous error
        '{ROW_ITEM, lfps_pkg::REG_KP, 16'h0, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, NO_RESULT},
        '{ROW_CFG, lfps_pkg::REG_BASE, 16'h0000, NO_SAMPLE, 1'b0, NO_RESULT},
        '{ROW_ITEM, lfps_pkg::REG_KP, 16'h0, '{8'd255, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, NO_RESULT},
        '{ROW_ITEM, lfps_pkg::REG_KP, 16'h0, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, NO_RESULT}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [lfps_pkg::PADDR_BITS-1:0] paddr;
    logic [lfps_pkg::PDATA_BITS-1:0] pwdata;
    logic [lfps_pkg::PDATA_BITS-1:0] prdata;
    logic pready;

    lfps_in_if #(.SENSOR_BITS(SENSOR_BITS)) sensor_in ();
    lfps_out_if result_out ();

    line_follow_pid_steering #(.SENSOR_BITS(SENSOR_BITS)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sensor_in  (sensor_in),
        .result_out (result_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // register copies and loop state of the steering law
    logic signed [lfps_pkg::GAIN_BITS-1:0]  kp_st = lfps_pkg::KP_RESET;
    logic signed [lfps_pkg::GAIN_BITS-1:0]  ki_st = lfps_pkg::KI_RESET;
    logic signed [lfps_pkg::GAIN_BITS-1:0]  kd_st = lfps_pkg::KD_RESET;
    logic [lfps_pkg::SPEED_BITS-1:0]        base_st = lfps_pkg::BASE_RESET;
    logic signed [7:0]                      integ_st = '0;
    logic signed [lfps_pkg::ERROR_BITS-1:0] prev_err_st = '0;

    steer_res_t steer_q [$];
    int mismatches = 0;
    int cycles = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    function automatic steer_res_t predict_steering(sample_t s);
        steer_res_t r;
        int sum;
        int num;
        int e;
        int d;
        int it;
        int drv;
        int duty1;
        int duty2;
        longint acc;
        longint q;
        sum = int'(s.far_left) + int'(s.left) + int'(s.center) + int'(s.right)
            + int'(s.far_right);
        num = -2 * int'(s.far_left) - int'(s.left) + int'(s.right) + 2 * int'(s.far_right);
        e = (sum == 0) ? 0 : (ERR_SCALE * num) / sum;
        it = int'(integ_st) + e;
        integ_st = 8'(it);
        d = e - int'(prev_err_st);
        acc = longint'(kp_st) * e + longint'(ki_st) * int'(integ_st) + longint'(kd_st) * d;
        q = acc / 256;
        if (q > 127)
            q = 127;
        if (q < -128)
            q = -128;
        drv = int'(q);
        duty1 = int'(base_st) - drv;
        duty2 = int'(base_st) + drv;
        prev_err_st = e[lfps_pkg::ERROR_BITS-1:0];
        r.position_error = e[lfps_pkg::ERROR_BITS-1:0];
        r.drive_value    = drv[lfps_pkg::DRIVE_BITS-1:0];
        r.duty_first     = duty1[lfps_pkg::DUTY_BITS-1:0];
        r.duty_second    = duty2[lfps_pkg::DUTY_BITS-1:0];
        r.no_signal      = (sum == 0);
        return r;
    endfunction

    function automatic void check_field(string what, int want, int got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d, got %0d", what, want, got);
        end
    endfunction

    function automatic int gap_cycles(int pct);
        int g;
        g = 0;
        while (g < MAX_GAP && $urandom_range(0, 99) < pct)
            g++;
        return g;
    endfunction

    function automatic logic [15:0] pick_gain();
        if ($urandom_range(0, 2) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 2047) - 1024);
    endfunction

    function automatic sample_t rand_sample();
        sample_t s;
        s = sample_t'({$urandom, 8'($urandom)});
        case ($urandom_range(0, 9))
            0: s = '0;
            1:
            begin
                s = '0;
                s = s | (40'($urandom_range(1, 255)) << (8 * $urandom_range(0, 4)));
            end
            2:
            begin
                s.far_left  = {8{$urandom_range(0, 1) == 1}};
                s.left      = {8{$urandom_range(0, 1) == 1}};
                s.center    = {8{$urandom_range(0, 1) == 1}};
                s.right     = {8{$urandom_range(0, 1) == 1}};
                s.far_right = {8{$urandom_range(0, 1) == 1}};
            end
            3, 4:
            begin
                s.far_left  = 8'($urandom_range(0, 3));
                s.left      = 8'($urandom_range(0, 3));
                s.center    = 8'($urandom_range(0, 3));
                s.right     = 8'($urandom_range(0, 3));
                s.far_right = 8'($urandom_range(0, 3));
            end
            default: ;
        endcase
        return s;
    endfunction

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] wdata);
        logic [lfps_pkg::PDATA_BITS-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            lfps_pkg::REG_KP:   kp_st = wdata[15:0];
            lfps_pkg::REG_KI:   ki_st = wdata[15:0];
            lfps_pkg::REG_KD:   kd_st = wdata[15:0];
            lfps_pkg::REG_BASE: base_st = wdata[7:0];
            default: ;
        endcase
        // back-to-back read of the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (!pready);
        rd = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        case (idx)
            lfps_pkg::REG_KP:
                check_field("kp_gain readback", int'(kp_st), int'($signed(rd[15:0])));
            lfps_pkg::REG_KI:
                check_field("ki_gain readback", int'(ki_st), int'($signed(rd[15:0])));
            lfps_pkg::REG_KD:
                check_field("kd_gain readback", int'(kd_st), int'($signed(rd[15:0])));
            lfps_pkg::REG_BASE:
                check_field("base_speed readback", int'(base_st), int'(rd[7:0]));
            default: ;
        endcase
    endtask

    task automatic send_item(input sample_t s, input int gap, input logic typed,
                             input steer_res_t typed_res);
        steer_res_t want;
        if (gap > 0)
        begin
            sensor_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sensor_in.valid            <= 1'b1;
        sensor_in.sensor_far_left  <= s.far_left;
        sensor_in.sensor_left      <= s.left;
        sensor_in.sensor_center    <= s.center;
        sensor_in.sensor_right     <= s.right;
        sensor_in.sensor_far_right <= s.far_right;
        do
            @(posedge clk);
        while (!sensor_in.ready);
        want = predict_steering(s);
        if (typed)
            want = typed_res;
        steer_q.push_back(want);
    endtask

    task automatic drain_results();
        sensor_in.valid <= 1'b0;
        do
            @(posedge clk);
        while (steer_q.size() != 0);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served       <= hold_requests;
            hold_left         <= HOLD_CYCLES;
            result_out.ready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left        <= hold_left - 1;
            result_out.ready <= 1'b0;
        end
        else
        begin
            result_out.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_out.valid && result_out.ready)
        begin
            if (steer_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result transaction with nothing outstanding");
            end
            else
            begin
                steer_res_t want;
                want = steer_q.pop_front();
                check_field("position_error", int'(want.position_error),
                            int'(result_out.position_error));
                check_field("drive_value", int'(want.drive_value), int'(result_out.drive_value));
                check_field("duty_first", int'(want.duty_first), int'(result_out.duty_first));
                check_field("duty_second", int'(want.duty_second), int'(result_out.duty_second));
                check_field("no_signal", int'(want.no_signal), int'(result_out.no_signal));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        idle_mode_t  mode;
        int          send_pct;
        int          gap;
        logic [15:0] kp_v;
        logic [15:0] ki_v;
        logic [15:0] kd_v;
        logic [7:0]  base_v;

        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        sensor_in.valid            = 1'b0;
        sensor_in.sensor_far_left  = '0;
        sensor_in.sensor_left      = '0;
        sensor_in.sensor_center    = '0;
        sensor_in.sensor_right     = '0;
        sensor_in.sensor_far_right = '0;
        result_out.ready           = 1'b0;
        send_pct = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_CFG)
            begin
                drain_results();
                reg_write(DIRECTED[i].reg_idx, {16'($urandom), DIRECTED[i].reg_val});
            end
            else
            begin
                send_item(DIRECTED[i].smp, 0, DIRECTED[i].typed, DIRECTED[i].res);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            mode = idle_mode_t'(ph % 4);
            drain_results();
            case (ph)
                0:
                begin
                    kp_v = 16'h7fff; ki_v = 16'h7fff; kd_v = 16'h7fff; base_v = 8'hff;
                end
                1:
                begin
                    kp_v = 16'h8000; ki_v = 16'h8000; kd_v = 16'h8000; base_v = 8'h00;
                end
                2:
                begin
                    kp_v = 16'(lfps_pkg::KP_RESET); ki_v = 16'(lfps_pkg::KI_RESET);
                    kd_v = 16'd64;
                    base_v = lfps_pkg::BASE_RESET;
                end
                default:
                begin
                    kp_v = pick_gain(); ki_v = pick_gain(); kd_v = pick_gain();
                    base_v = 8'($urandom);
                end
            endcase
            reg_write(lfps_pkg::REG_KP, {16'($urandom), kp_v});
            reg_write(lfps_pkg::REG_KI, {16'($urandom), ki_v});
            reg_write(lfps_pkg::REG_KD, {16'($urandom), kd_v});
            reg_write(lfps_pkg::REG_BASE, {24'($urandom), base_v});
            case (mode)
                IDLE_NONE: begin send_pct = 0;  stall_pct <= 0;  end
                IDLE_SEND: begin send_pct = 65; stall_pct <= 0;  end
                IDLE_RECV: begin send_pct = 0;  stall_pct <= 65; end
                default:   begin send_pct = 25; stall_pct <= 25; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // long receiver hold-off while items keep coming
                if (ph == 2 && n == 40)
                    hold_requests <= hold_requests + 1;
                if (ph == 5 && n == 50)
                    drain_results();
                gap = (ph == 2 && n >= 40 && n < 48) ? 0 : gap_cycles(send_pct);
                send_item(rand_sample(), gap, 1'b0, NO_RESULT);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (steer_q.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
